// File: rtl/heron_pkg.sv
`default_nettype none

package heron_pkg;

  localparam int SIDE_BITS  = 12;
  localparam int PERIM_BITS = SIDE_BITS + 2;
  localparam int TERM_BITS  = SIDE_BITS + 1;
  localparam int AREA_BITS  = 2 * SIDE_BITS + 1;

  // Partial products: P * ta and tb * tc, then their product.
  localparam int MUL1_BITS = PERIM_BITS + TERM_BITS;
  localparam int MUL2_BITS = 2 * TERM_BITS;
  localparam int PROD_BITS = MUL1_BITS + MUL2_BITS;

  // Digit-by-digit square root: one root bit per step, several steps per stage.
  localparam int ROOT_BITS       = (PROD_BITS + 1) / 2;
  localparam int RAD_BITS        = 2 * ROOT_BITS;
  localparam int REM_BITS        = ROOT_BITS + 2;
  localparam int STEPS_PER_STAGE = 3;
  localparam int SQ_STAGES       = (ROOT_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // Input register, two multiplier stages, then the root stages.
  localparam int LATENCY = 3 + SQ_STAGES;

  typedef struct packed {
    logic [RAD_BITS-1:0]   rad;
    logic [REM_BITS-1:0]   rem;
    logic [ROOT_BITS-1:0]  root;
    logic [PERIM_BITS-1:0] perim;
    logic                  bad;
  } sq_stage_t;

endpackage

`default_nettype wire

// File: rtl/heron_triangle_area_core.sv
`default_nettype none

// Heron triangle area core.
// Command channel: side_a_i, side_b_i and side_c_i (unsigned, units of 1/16)
// are taken in a transfer at each rising edge where start_i is high and busy_o
// is low. busy_o is held low, so a new triangle may be started in every cycle.
// Result channel: done_o is high for exactly one cycle with perimeter_o,
// area_o and invalid_o; the result must be taken in that cycle, as the
// receiver cannot hold it off and nothing is stored for it.
// The sums and triangle check are registered first, then the two partial
// products and their full product, and each group of three root bits of the
// digit-by-digit square root has its own pipeline register.
// Throughput is one triangle per cycle; every stage is a plain pipeline
// register with a valid bit travelling alongside the data.
// area_o is floor(sqrt(P(b+c-a)(a-b+c)(a+b-c))), which is the area in units
// of 1/1024. When one side exceeds the sum of the other two, invalid_o is set
// and area_o is zero; perimeter_o still carries the sum.
// Reset clears every valid bit, so no result appears until a new start.
module heron_triangle_area_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [heron_pkg::SIDE_BITS-1:0]     side_a_i,
  input  logic [heron_pkg::SIDE_BITS-1:0]     side_b_i,
  input  logic [heron_pkg::SIDE_BITS-1:0]     side_c_i,
  output logic                                busy_o,
  output logic                                done_o,
  output logic [heron_pkg::PERIM_BITS-1:0]    perimeter_o,
  output logic [heron_pkg::AREA_BITS-1:0]     area_o,
  output logic                                invalid_o
);
  import heron_pkg::*;

  logic accept;

  // Stage 1: perimeter, difference terms and triangle check.
  logic [TERM_BITS-1:0]  sum_ab, sum_ac, sum_bc;
  logic [PERIM_BITS-1:0] perim_d;
  logic                  bad_d;
  logic [TERM_BITS-1:0]  ta_d, tb_d, tc_d;

  logic                  s1_vld_q;
  logic [PERIM_BITS-1:0] s1_perim_q;
  logic                  s1_bad_q;
  logic [TERM_BITS-1:0]  s1_ta_q, s1_tb_q, s1_tc_q;

  // Stage 2: two partial products.
  logic                  s2_vld_q;
  logic [MUL1_BITS-1:0]  s2_m1_q;
  logic [MUL2_BITS-1:0]  s2_m2_q;
  logic [PERIM_BITS-1:0] s2_perim_q;
  logic                  s2_bad_q;

  // Stage 3 is sq_q[0]: the full product waiting for the root stages.
  logic                  sq_vld_q [SQ_STAGES+1];
  sq_stage_t             sq_q     [SQ_STAGES+1];
  sq_stage_t             sq_d     [SQ_STAGES+1];

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign sum_ab  = TERM_BITS'(side_a_i) + TERM_BITS'(side_b_i);
  assign sum_ac  = TERM_BITS'(side_a_i) + TERM_BITS'(side_c_i);
  assign sum_bc  = TERM_BITS'(side_b_i) + TERM_BITS'(side_c_i);
  assign perim_d = PERIM_BITS'(sum_ab) + PERIM_BITS'(side_c_i);
  assign bad_d   = (TERM_BITS'(side_a_i) > sum_bc) ||
                   (TERM_BITS'(side_b_i) > sum_ac) ||
                   (TERM_BITS'(side_c_i) > sum_ab);

  // A zero term drives the product, and so the area, to zero.
  assign ta_d = bad_d ? '0 : sum_bc - TERM_BITS'(side_a_i);
  assign tb_d = bad_d ? '0 : sum_ac - TERM_BITS'(side_b_i);
  assign tc_d = bad_d ? '0 : sum_ab - TERM_BITS'(side_c_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      sq_vld_q[0] <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      sq_vld_q[0] <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_perim_q <= perim_d;
      s1_bad_q   <= bad_d;
      s1_ta_q    <= ta_d;
      s1_tb_q    <= tb_d;
      s1_tc_q    <= tc_d;
    end
    if (s1_vld_q) begin
      s2_m1_q    <= MUL1_BITS'(s1_perim_q) * MUL1_BITS'(s1_ta_q);
      s2_m2_q    <= MUL2_BITS'(s1_tb_q) * MUL2_BITS'(s1_tc_q);
      s2_perim_q <= s1_perim_q;
      s2_bad_q   <= s1_bad_q;
    end
    if (s2_vld_q) begin
      sq_q[0] <= sq_d[0];
    end
  end

  always_comb begin
    sq_d[0].rad   = RAD_BITS'(PROD_BITS'(s2_m1_q) * PROD_BITS'(s2_m2_q));
    sq_d[0].rem   = '0;
    sq_d[0].root  = '0;
    sq_d[0].perim = s2_perim_q;
    sq_d[0].bad   = s2_bad_q;
  end

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sqrt
    always_comb begin : step_comb
      sq_stage_t            cur;
      logic [REM_BITS-1:0]  rem_sh;
      logic [REM_BITS-1:0]  trial;
      cur    = sq_q[s];
      rem_sh = '0;
      trial  = '0;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        if (s * STEPS_PER_STAGE + k < ROOT_BITS) begin
          // Bring down the next two radicand bits and try the next root bit.
          rem_sh  = {cur.rem[REM_BITS-3:0], cur.rad[RAD_BITS-1 -: 2]};
          trial   = {cur.root, 2'b01};
          cur.rad = {cur.rad[RAD_BITS-3:0], 2'b00};
          if (rem_sh >= trial) begin
            cur.rem  = rem_sh - trial;
            cur.root = {cur.root[ROOT_BITS-2:0], 1'b1};
          end else begin
            cur.rem  = rem_sh;
            cur.root = {cur.root[ROOT_BITS-2:0], 1'b0};
          end
        end
      end
      sq_d[s+1] = cur;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[s+1] <= 1'b0;
      end else begin
        sq_vld_q[s+1] <= sq_vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (sq_vld_q[s]) begin
        sq_q[s+1] <= sq_d[s+1];
      end
    end
  end

  assign done_o      = sq_vld_q[SQ_STAGES];
  assign perimeter_o = sq_q[SQ_STAGES].perim;
  assign area_o      = sq_q[SQ_STAGES].root[AREA_BITS-1:0];
  assign invalid_o   = sq_q[SQ_STAGES].bad;

`ifndef SYNTHESIS
  // A result carries the perimeter of the triangle that was started for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> perimeter_o == $past(perim_d, LATENCY))
    else $error("perimeter does not match the started triangle");

  // The triangle check travels with its item through the whole pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> invalid_o == $past(bad_d, LATENCY))
    else $error("invalid flag does not match the started triangle");

  // An impossible triangle must come out with a zero area.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && invalid_o) |-> area_o == '0)
    else $error("nonzero area on an invalid triangle");
`endif

endmodule

`default_nettype wire
